### src/i2cmrt_pkg.sv
// package: sequencer states, field widths and constants for the i2c register master
package i2cmrt_pkg;

  localparam int unsigned QuarterW = 16;
  localparam logic [QuarterW-1:0] QuarterReset = 16'd30;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START,
    ST_DEVW_BITS, ST_DEVW_ACK,
    ST_AHI_BITS, ST_AHI_ACK,
    ST_ALO_BITS, ST_ALO_ACK,
    ST_WAIT_DATA,
    ST_DATA_BITS, ST_DATA_ACK,
    ST_RSTART,
    ST_DEVR_BITS, ST_DEVR_ACK,
    ST_RD_BITS, ST_RD_ACK,
    ST_STOP
  } seq_state_e;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       command_valid;
    logic       operation;
    logic [7:0] device_address;
    logic [15:0] register_address;
    logic       wide_address;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       write_data_valid;
  } tick_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       write_data_taken;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } result_t;

endpackage

### src/i2cmrt_if.sv
// interfaces: ready/valid tick and result word channels and configuration write channel
interface i2cmrt_tick_if
  import i2cmrt_pkg::*;
;
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cmrt_res_if
  import i2cmrt_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cmrt_cfg_if
  import i2cmrt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [QuarterW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/i2cmrt_core.sv
// core: one tick of the bus sequencer, state registers and result computation
module i2cmrt_core
  import i2cmrt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  tick_t               tick_i,
  input  logic [QuarterW-1:0] quarter_i,
  output result_t             res_o
);

  seq_state_e          state_q, state_d;
  logic [QuarterW-1:0] dly_q, dly_d;
  logic [1:0]          ph_q, ph_d;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          sh_q, sh_d;
  logic [7:0]          left_q, left_d;
  logic [7:0]          dev_q, dev_d;
  logic [15:0]         reg_q, reg_d;
  logic                wide_q, wide_d, rd_q, rd_d;
  logic                scl_q, scl_d, sda_q, sda_d;
  logic [QuarterW-1:0] q_eff;
  logic [QuarterW:0]   dly_inc;
  logic                tx_bits, bit_state;
  logic [7:0]          rd_byte, left_dec;
  result_t             r;

  always_comb begin
    q_eff   = (quarter_i == '0) ? QuarterW'(1) : quarter_i;
    dly_inc = {1'b0, dly_q} + 1'b1;
    tx_bits = (state_q == ST_DEVW_BITS) || (state_q == ST_AHI_BITS) ||
              (state_q == ST_ALO_BITS) || (state_q == ST_DATA_BITS) ||
              (state_q == ST_DEVR_BITS);
    bit_state = !((state_q == ST_IDLE) || (state_q == ST_START) ||
                  (state_q == ST_RSTART) || (state_q == ST_STOP) ||
                  (state_q == ST_WAIT_DATA));
    rd_byte  = {sh_q[6:0], tick_i.sda_level};
    left_dec = left_q - 8'd1;
  end

  always_comb begin
    state_d = state_q; dly_d = dly_q; ph_d = ph_q; bit_d = bit_q; sh_d = sh_q;
    left_d = left_q; dev_d = dev_q; reg_d = reg_q; wide_d = wide_q; rd_d = rd_q;
    scl_d = scl_q; sda_d = sda_q;
    r = '0;
    // enter() is written as: state, phase, delay, bit count, shift byte
    if (state_q == ST_IDLE) begin
      if (tick_i.command_valid) begin
        dev_d = tick_i.device_address; reg_d = tick_i.register_address;
        wide_d = tick_i.wide_address; rd_d = tick_i.operation;
        left_d = tick_i.byte_count;
        state_d = ST_START; ph_d = '0; dly_d = '0; bit_d = '0; sh_d = '0;
      end
    end else if (state_q == ST_WAIT_DATA) begin
      if (tick_i.write_data_valid) begin
        r.write_data_taken = 1'b1;
        state_d = ST_DATA_BITS; ph_d = '0; dly_d = '0; bit_d = '0;
        sh_d = tick_i.write_data;
      end
    end else if (dly_inc < {1'b0, q_eff}) begin
      dly_d = dly_inc[QuarterW-1:0];
    end else if (bit_state) begin
      if (!(ph_q == 2'd2 && !tick_i.scl_level)) begin
        dly_d = '0;
        unique case (ph_q)
          2'd0: begin
            scl_d = 1'b1;
            sda_d = tx_bits ? !sh_q[7] :
                    (state_q == ST_RD_ACK) ? (left_q > 8'd1) : 1'b0;
            ph_d = 2'd1;
          end
          2'd1: begin scl_d = 1'b0; ph_d = 2'd2; end
          2'd2: ph_d = 2'd3;
          default: begin
            scl_d = 1'b1;
            if (tx_bits) begin
              sh_d = {sh_q[6:0], 1'b0};
              if (bit_q == 3'd7) begin
                state_d = seq_state_e'(state_q + 5'd1);
                ph_d = '0; bit_d = '0; sh_d = '0;
              end else begin
                bit_d = bit_q + 3'd1; ph_d = '0;
              end
            end else if (state_q == ST_RD_BITS) begin
              sh_d = rd_byte;
              if (bit_q == 3'd7) begin
                r.read_data = rd_byte; r.read_valid = 1'b1;
                state_d = ST_RD_ACK; ph_d = '0; bit_d = '0;
              end else begin
                bit_d = bit_q + 3'd1; ph_d = '0;
              end
            end else if (state_q == ST_RD_ACK) begin
              left_d = left_dec; ph_d = '0; bit_d = '0; sh_d = '0;
              state_d = (left_dec != '0) ? ST_RD_BITS : ST_STOP;
            end else if (tick_i.sda_level) begin
              state_d = ST_STOP; ph_d = '0; bit_d = 3'd1; sh_d = '0;
            end else begin
              ph_d = '0; bit_d = '0; sh_d = '0;
              priority case (state_q)
                ST_DEVW_ACK: begin
                  state_d = wide_q ? ST_AHI_BITS : ST_ALO_BITS;
                  sh_d = wide_q ? reg_q[15:8] : reg_q[7:0];
                end
                ST_AHI_ACK: begin state_d = ST_ALO_BITS; sh_d = reg_q[7:0]; end
                ST_ALO_ACK:
                  state_d = rd_q ? ST_RSTART :
                            (left_q != '0) ? ST_WAIT_DATA : ST_STOP;
                ST_DATA_ACK: begin
                  left_d = left_dec;
                  state_d = (left_dec != '0) ? ST_WAIT_DATA : ST_STOP;
                end
                default: state_d = (left_q != '0) ? ST_RD_BITS : ST_STOP;
              endcase
            end
          end
        endcase
      end
    end else begin
      dly_d = '0;
      ph_d = ph_q + 2'd1;
      if (state_q == ST_STOP) begin
        unique case (ph_q)
          2'd0: scl_d = 1'b1;
          2'd1: sda_d = 1'b1;
          2'd2: scl_d = 1'b0;
          default: begin
            sda_d = 1'b0; r.done_res = 1'b1; r.status = bit_q[0];
            state_d = ST_IDLE; ph_d = '0; bit_d = '0; sh_d = '0;
          end
        endcase
      end else begin
        unique case (ph_q)
          2'd0: sda_d = 1'b0;
          2'd1: scl_d = 1'b0;
          2'd2: sda_d = 1'b1;
          default: begin
            scl_d = 1'b1; ph_d = '0; bit_d = '0;
            if (state_q == ST_START) begin
              state_d = ST_DEVW_BITS; sh_d = {dev_q[7:1], 1'b0};
            end else begin
              state_d = ST_DEVR_BITS; sh_d = {dev_q[7:1], 1'b1};
            end
          end
        endcase
      end
    end
    r.scl_drive_low = scl_d;
    r.sda_drive_low = sda_d;
    r.busy_res      = (state_d != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; dly_q <= '0; ph_q <= '0; bit_q <= '0; sh_q <= '0;
      left_q <= '0; dev_q <= '0; reg_q <= '0; wide_q <= 1'b0; rd_q <= 1'b0;
      scl_q <= 1'b0; sda_q <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d; dly_q <= dly_d; ph_q <= ph_d; bit_q <= bit_d;
      sh_q <= sh_d; left_q <= left_d; dev_q <= dev_d; reg_q <= reg_d;
      wide_q <= wide_d; rd_q <= rd_d; scl_q <= scl_d; sda_q <= sda_d;
    end
  end

  assign res_o = r;

endmodule

### src/i2c_master_register_transfer.sv
// top level: i2c register read/write master, one tick word in, one result word out
// result: the result word of a tick word is computed combinationally and written to the
//   output register at the edge that accepts the tick word
// throughput: one tick word per cycle, set by the combinational sequencer step
//   and the output register that frees whenever its word is taken
// reset: asynchronous active low; sequencer idle, both bus lines released,
//   quarter period back to 30 ticks, output register empty
module i2c_master_register_transfer
  import i2cmrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cmrt_tick_if.sink   in_i,
  i2cmrt_cfg_if.sink    cfg_i,
  i2cmrt_res_if.source  out_o
);

  logic [QuarterW-1:0] quarter_q;
  logic                ovalid_q;
  result_t             odata_q;
  result_t             res;
  logic                step;

  // output register may take a new word when empty or being drained
  assign in_i.ready = !ovalid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  i2cmrt_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .tick_i    (in_i.data),
    .quarter_i (quarter_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quarter_q <= QuarterReset;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) quarter_q <= cfg_i.data;
      if (step) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (step) odata_q <= res;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;

endmodule

### src/i2cmrt_checker.sv
// checker: port-level assertions for the i2c register master, with bind
module i2cmrt_checker
  import i2cmrt_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input result_t out_data_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled with free output register");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.done_res |-> !out_data_i.busy_res)
    else $error("done reported while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status |-> out_data_i.done_res)
    else $error("status without done");

  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.read_valid |-> out_data_i.read_data == 8'd0)
    else $error("read data without read valid");

endmodule

bind i2c_master_register_transfer i2cmrt_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
